@@ src/svl_pkg.sv @@
// ----------------------------------------------------------------------------
// svl_pkg: shared types and constants of the sorted value list
// Holds the capacity, the operation and status codes, and the structs that
// carry commands and neighbour links along the chain of storage cells.
// ----------------------------------------------------------------------------
package svl_pkg;

	localparam int CAPACITY = 16;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic                    ins_en;
		logic                    del_en;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic                    less;
		logic                    match;
		logic                    valid;
		logic signed [VAL_W-1:0] value;
	} link_t;

	// The head of the chain behaves as if a smaller value stood before it.
	localparam link_t LINK_HEAD = '{less: 1'b1, match: 1'b0, valid: 1'b0, value: '0};
	localparam link_t LINK_TAIL = '{less: 1'b0, match: 1'b0, valid: 1'b0, value: '0};

endpackage

@@ src/svl_cell.sv @@
// ----------------------------------------------------------------------------
// svl_cell: one slot of the sorted value list
// Holds one value and its valid bit, compares it with the command value and
// takes the new value, its left neighbour's or its right neighbour's entry.
// ----------------------------------------------------------------------------
module svl_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  svl_pkg::cmd_t  cmd,
	input  svl_pkg::link_t left,
	input  svl_pkg::link_t right,
	output svl_pkg::link_t self
);
	import svl_pkg::*;

	logic                    valid_q;
	logic signed [VAL_W-1:0] val_q;
	logic                    take_v;

	always_comb begin
		self.less  = valid_q && (val_q < cmd.value);
		self.match = valid_q && (val_q == cmd.value);
		self.valid = valid_q;
		self.value = val_q;
		take_v     = !self.less && left.less;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.ins_en && !self.less) begin
			valid_q <= take_v ? 1'b1 : left.valid;
		end else if (cmd.del_en && !self.less) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ins_en && !self.less) begin
			val_q <= take_v ? cmd.value : left.value;
		end else if (cmd.del_en && !self.less) begin
			val_q <= right.value;
		end
	end

endmodule

@@ src/sorted_value_list_core.sv @@
// ----------------------------------------------------------------------------
// sorted_value_list_core: ordered store of signed values in a chain of cells
// Keeps up to sixteen values in ascending order and inserts or deletes one
// value per transaction, answering with a status and the list summary.
// ----------------------------------------------------------------------------
// The input channel carries one transaction per operation: bit 0 of tdata is
// the opcode (insert or delete) and bits 32..1 are the signed value. Each
// accepted transaction yields exactly one output transaction with the status,
// the count after the operation, the empty flag and the smallest value.
// Every cell compares its entry with the value in parallel and shifts towards
// its neighbour in the same cycle. The result is registered and appears on
// the output in the cycle after acceptance; while the receiver keeps up, one
// transaction can be taken in every cycle. The output register is the only
// buffering; while the receiver stalls with a result pending, the input is
// held off, and a new transaction is taken in the very cycle that the pending
// result is taken. Reset empties the list and clears the output valid.
// ----------------------------------------------------------------------------
module sorted_value_list_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // opcode[0], value[32:1], zero padding
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata   // status[1:0], count[6:2],
	                                   // is_list_empty[7], smallest[39:8]
);
	import svl_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	link_t                   lk [CAPACITY];
	cmd_t                    cmd;
	logic                    accept;
	op_t                     opcode;
	logic signed [VAL_W-1:0] value;
	logic                    found;
	logic                    full;
	logic                    empty;
	status_t                 status;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        cnt_nxt;
	logic                    head_valid;
	logic signed [VAL_W-1:0] head_value;
	logic                    out_valid_q;
	logic [39:0]             out_data_q;

	assign opcode        = op_t'(s_axis_tdata[0]);
	assign value         = s_axis_tdata[32:1];
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign full          = (cnt_q == CAP_CNT);
	assign empty         = (cnt_q == '0);

	always_comb begin
		found = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			found = found | lk[i].match;
		end
	end

	always_comb begin
		cmd.value  = value;
		cmd.ins_en = accept && (opcode == OP_INSERT) && !full;
		cmd.del_en = accept && (opcode == OP_DELETE) && found;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		link_t left_lk;
		link_t right_lk;

		if (i == 0) begin : g_head
			assign left_lk = LINK_HEAD;
		end else begin : g_left
			assign left_lk = lk[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_lk = LINK_TAIL;
		end else begin : g_right
			assign right_lk = lk[i+1];
		end

		svl_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.cmd   (cmd),
			.left  (left_lk),
			.right (right_lk),
			.self  (lk[i])
		);
	end

	always_comb begin
		status  = ST_OK;
		cnt_nxt = cnt_q;
		if (opcode == OP_INSERT) begin
			if (full) begin
				status = ST_FULL;
			end else begin
				cnt_nxt = cnt_q + 1'b1;
			end
		end else if (empty) begin
			status = ST_EMPTY;
		end else if (!found) begin
			status = ST_NOT_FOUND;
		end else begin
			cnt_nxt = cnt_q - 1'b1;
		end
	end

	always_comb begin
		head_valid = lk[0].valid;
		head_value = lk[0].value;
		if (cmd.ins_en && !lk[0].less) begin
			head_valid = 1'b1;
			head_value = value;
		end else if (cmd.del_en && !lk[0].less) begin
			head_valid = lk[1].valid;
			head_value = lk[1].value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				cnt_q       <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q[1:0]  <= status;
			out_data_q[6:2]  <= 5'(cnt_nxt);
			out_data_q[7]    <= (cnt_nxt == '0);
			out_data_q[39:8] <= head_valid ? head_value : '0;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
